[rtl/bf3_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants, types and result codes of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 64;
  localparam int PIXEL_BITS   = 8;

  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT);

  // nine samples need four extra bits
  localparam int SUM_W     = PIXEL_BITS + 4;
  // floor(s/9) == (s * DIV_MUL) >> DIV_SHIFT for every s below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + 3;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + 8) / 9;
  localparam int MULC_W    = $clog2(DIV_MUL + 1);
  localparam int PROD_W    = SUM_W + MULC_W;

  // result kinds raised by one item, emitted lowest first
  localparam int NUM_KINDS         = 4;
  localparam int RES_PREV_ROW      = 0;  // (y-1, x-1)
  localparam int RES_LAST_ROW      = 1;  // (y, x-1) on the last row
  localparam int RES_PREV_ROW_EDGE = 2;  // (y-1, W-1) at the last column
  localparam int RES_LAST_ROW_EDGE = 3;  // (y, W-1) bottom-right corner

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [NUM_KINDS-1:0]  kind_mask_t;

  localparam row_t ROW_LAST = row_t'(FRAME_HEIGHT - 1);
  localparam col_t COL_LAST = col_t'(FRAME_WIDTH - 1);

  // one new window column: two rows from the line buffers plus the input
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
    row_t row;
    col_t col;
  } colvec_t;

  // one result waiting for the divide
  typedef struct packed {
    sum_t sum;
    row_t row;
    col_t col;
    logic run_end;
    logic frame_done;
  } job_t;

endpackage
`default_nettype wire

[rtl/bf3_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_if
// Valid/ready channels of the box filter: sample input and result output.
// ----------------------------------------------------------------------------
interface bf3_in_if import bf3_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bf3_out_if import bf3_pkg::*; ();
  logic valid;
  logic ready;
  row_t out_row;
  col_t out_col;
  pix_t mean_value;
  logic run_end;
  logic frame_done;

  modport source (output valid, output out_row, output out_col, output mean_value,
                  output run_end, output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input mean_value,
                  input run_end, input frame_done, output ready);
endinterface
`default_nettype wire

[rtl/bf3_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bf3_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/bf3_linebuf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_linebuf
// Raster position counters, two line buffers and the input stage. Hands the
// window one column per item: rows y-2, y-1 and the new sample of row y.
// ----------------------------------------------------------------------------
module bf3_linebuf import bf3_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bf3_in_if.sink       in_ch,
  output      logic    cv_valid,
  output      colvec_t cv,
  input  wire logic    cv_ready
);

  row_t row_r, row_nxt;
  col_t col_r, col_nxt;
  logic s1_v_r, s1_v_nxt;
  pix_t s1_pix_r;
  row_t s1_row_r;
  col_t s1_col_r;
  pix_t rd_prev;   // row y-1
  pix_t rd_prev2;  // row y-2
  logic acc;
  logic adv;

  assign in_ch.ready = !s1_v_r || cv_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign adv         = s1_v_r && cv_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (col_r == COL_LAST) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_LAST) ? '0 : row_r + row_t'(1);
      end else begin
        col_nxt = col_r + col_t'(1);
      end
    end
    s1_v_nxt = acc ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= in_ch.pixel_value;
      s1_row_r <= row_r;
      s1_col_r <= col_r;
    end
  end

  // line y-1; written with the sample as it leaves the input stage
  bf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(FRAME_WIDTH)) u_line_prev (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (acc),
    .raddr (col_r),
    .rdata (rd_prev)
  );

  // line y-2; takes over what line y-1 held at that column
  bf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(FRAME_WIDTH)) u_line_prev2 (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_col_r),
    .wdata (rd_prev),
    .re    (acc),
    .raddr (col_r),
    .rdata (rd_prev2)
  );

  assign cv_valid = s1_v_r;
  assign cv.top   = rd_prev2;
  assign cv.mid   = rd_prev;
  assign cv.bot   = s1_pix_r;
  assign cv.row   = s1_row_r;
  assign cv.col   = s1_col_r;

endmodule
`default_nettype wire

[rtl/bf3_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_window
// 3x3 sample window, result sequencer and nine-tap sum. Emits the results of
// the newest column one per cycle while job_ready allows, with out-of-frame taps taken as center.
// ----------------------------------------------------------------------------
module bf3_window import bf3_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cv_valid,
  input  wire colvec_t cv,
  output      logic    cv_ready,
  output      logic    job_valid,
  output      job_t    job,
  input  wire logic    job_ready
);

  pix_t       win_r [3][3];  // [column: oldest..newest][row: top..bot]
  row_t       y_r;
  col_t       x_r;
  kind_mask_t pend_r, pend_nxt;
  logic       job_v_r, job_v_nxt;
  job_t       job_r, job_nxt;

  kind_mask_t pick_oh;
  kind_mask_t pend_rest;
  kind_mask_t pend_load;
  logic       last;
  logic       emit;
  logic       load;
  logic       sel_bot;
  logic       sel_right;
  row_t       r_row;
  col_t       r_col;
  logic       top_out, bot_out, left_out, right_out;
  pix_t       center;
  pix_t       tap [3][3];
  sum_t       sum_nxt;

  assign pick_oh   = pend_r & (~pend_r + kind_mask_t'(1));
  assign pend_rest = pend_r & (pend_r - kind_mask_t'(1));
  assign last      = (pend_rest == '0);
  assign emit      = (pend_r != '0) && (!job_v_r || job_ready);
  assign cv_ready  = (pend_r == '0) || (emit && last);
  assign load      = cv_valid && cv_ready;

  always_comb begin
    pend_load                    = '0;
    pend_load[RES_PREV_ROW]      = (cv.col != '0) && (cv.row != '0);
    pend_load[RES_LAST_ROW]      = (cv.col != '0) && (cv.row == ROW_LAST);
    pend_load[RES_PREV_ROW_EDGE] = (cv.col == COL_LAST) && (cv.row != '0);
    pend_load[RES_LAST_ROW_EDGE] = (cv.col == COL_LAST) && (cv.row == ROW_LAST);
  end

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = pend_load;
    end else if (emit) begin
      pend_nxt = pend_rest;
    end
    job_v_nxt = emit ? 1'b1 : (job_ready ? 1'b0 : job_v_r);
  end

  // center of the picked result within the window
  assign sel_bot   = pick_oh[RES_LAST_ROW] | pick_oh[RES_LAST_ROW_EDGE];
  assign sel_right = pick_oh[RES_PREV_ROW_EDGE] | pick_oh[RES_LAST_ROW_EDGE];
  assign r_row     = sel_bot ? y_r : y_r - row_t'(1);
  assign r_col     = sel_right ? x_r : x_r - col_t'(1);
  assign top_out   = (r_row == '0);
  assign bot_out   = (r_row == ROW_LAST);
  assign left_out  = (r_col == '0);
  assign right_out = (r_col == COL_LAST);

  always_comb begin
    center  = win_r[2'd1 + 2'(sel_right)][2'd1 + 2'(sel_bot)];
    sum_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap[i][j] = center;
        if (!((i == 0 && top_out) || (i == 2 && bot_out) ||
              (j == 0 && left_out) || (j == 2 && right_out))) begin
          tap[i][j] = win_r[2'(j) + 2'(sel_right)][2'(i) + 2'(sel_bot)];
        end
        sum_nxt = sum_nxt + SUM_W'(tap[i][j]);
      end
    end
  end

  always_comb begin
    job_nxt.sum        = sum_nxt;
    job_nxt.row        = r_row;
    job_nxt.col        = r_col;
    job_nxt.run_end    = last;
    job_nxt.frame_done = pick_oh[RES_LAST_ROW_EDGE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      job_v_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      job_v_r <= job_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= '{cv.top, cv.mid, cv.bot};
      y_r      <= cv.row;
      x_r      <= cv.col;
    end
    if (emit) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_v_r;
  assign job       = job_r;

endmodule
`default_nettype wire

[rtl/bf3_mean.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_mean
// Divide by nine through a reciprocal multiply, into the output register.
// ----------------------------------------------------------------------------
module bf3_mean import bf3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  wire job_t job,
  output      logic job_ready,
  bf3_out_if.source out_ch
);

  localparam logic [PROD_W-1:0] RECIP = PROD_W'(DIV_MUL);

  logic              out_v_r, out_v_nxt;
  row_t              row_r;
  col_t              col_r;
  pix_t              mean_r;
  logic              run_end_r;
  logic              frame_done_r;
  logic [PROD_W-1:0] prod;
  logic              take;

  assign job_ready = !out_v_r || out_ch.ready;
  assign take      = job_valid && job_ready;
  assign prod      = PROD_W'(job.sum) * RECIP;
  assign out_v_nxt = take ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_r        <= job.row;
      col_r        <= job.col;
      mean_r       <= prod[DIV_SHIFT +: PIXEL_BITS];
      run_end_r    <= job.run_end;
      frame_done_r <= job.frame_done;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_row    = row_r;
  assign out_ch.out_col    = col_r;
  assign out_ch.mean_value = mean_r;
  assign out_ch.run_end    = run_end_r;
  assign out_ch.frame_done = frame_done_r;

endmodule
`default_nettype wire

[rtl/box_filter_3x3_edge_center_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_center_unit
// 3x3 truncated-mean filter over a raster-scanned frame, edges padded with
// the center sample.
//
//   channel  dir  payload                                        handshake
//   in_ch    in   pixel_value                                    valid/ready
//   out_ch   out  out_row, out_col, mean_value, run_end,         valid/ready
//                 frame_done
//
// One item per cycle while it raises at most one result and out_ch does not
// stall. An item raising two to four results (row ends, last row) holds off
// the next item, and so in_ch.ready, until its last result is emitted: the
// window stage emits one result per cycle when job_ready allows. Four
// register stages (input, window, sum, output) lie between in_ch and out_ch.
// Reset clears the position counters and all valid flags; line buffers are
// not cleared and their contents are never used at rows not yet written.
// Stalls on out_ch back up through the stages to in_ch.ready.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_center_unit import bf3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bf3_in_if.sink    in_ch,
  bf3_out_if.source out_ch
);

  logic    cv_valid;
  colvec_t cv;
  logic    cv_ready;
  logic    job_valid;
  job_t    job;
  logic    job_ready;

  bf3_linebuf u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cv_valid (cv_valid),
    .cv       (cv),
    .cv_ready (cv_ready)
  );

  bf3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cv_valid  (cv_valid),
    .cv        (cv),
    .cv_ready  (cv_ready),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  bf3_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

  a_frame_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done |->
      out_ch.run_end && out_ch.out_row == ROW_LAST && out_ch.out_col == COL_LAST)
    else $error("frame_done away from the last result of the corner");

  a_job_corner_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job.frame_done |-> job.run_end)
    else $error("corner result not last of its item");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !job_valid && !cv_valid)
    else $error("stage valid after reset");

endmodule
`default_nettype wire
